// File: sv/tmix_pkg.sv
`default_nettype none

package tmix_pkg;

    localparam int DIV_W  = 64;   // dividend and quotient width of the shared divider
    localparam int DVS_W  = 32;   // divisor width
    localparam int SQ_W   = 64;   // radicand width of the root unit
    localparam int ROOT_W = 32;   // root width
    localparam int SUM_W  = 40;   // accumulator width, Q13.27
    localparam int CFG_W  = 32;   // widest configuration register

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [46:0] N_CAP   = 47'h7FFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        CFG_LINEAR    = 2'd0,
        CFG_QUADRATIC = 2'd1,
        CFG_MAX_REVS  = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_CONTROL = 1'b1
    } op_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

`default_nettype wire

// File: sv/tmix_ram.sv
`default_nettype none

module tmix_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/tmix_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module tmix_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tmix_pkg::div_req_t  req,
    output tmix_pkg::div_rsp_t       rsp
);

    localparam int DW    = tmix_pkg::DIV_W;
    localparam int VW    = tmix_pkg::DVS_W;
    localparam int CNT_W = $clog2(DW);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    dvd_reg;
    logic [VW-1:0]    dvs_reg;
    logic [VW-1:0]    rem_reg;

    logic [VW:0]      shifted;
    logic             qbit;
    logic [VW:0]      diff;
    logic [VW-1:0]    rem_next;

    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[DW-1]};
        diff     = shifted - {1'b0, dvs_reg};
        qbit     = (shifted >= {1'b0, dvs_reg});
        rem_next = qbit ? diff[VW-1:0] : shifted[VW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!run_reg && req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // hold operands, shift the quotient in behind the dividend
    always_ff @(posedge clk)
    begin
        if (!run_reg && req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

`default_nettype wire

// File: sv/tmix_sqrt.sv
`default_nettype none

// Digit-recurrence integer square root, one root bit per cycle.
module tmix_sqrt (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tmix_pkg::sqrt_req_t  req,
    output tmix_pkg::sqrt_rsp_t       rsp
);

    localparam int SW    = tmix_pkg::SQ_W;
    localparam int RW    = tmix_pkg::ROOT_W;
    localparam int CNT_W = $clog2(RW);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SW-1:0]    rad_reg;
    logic [RW-1:0]    root_reg;
    logic [RW+1:0]    rem_reg;

    logic [RW+3:0]    partial;
    logic [RW+3:0]    trial;
    logic             take;
    logic [RW+3:0]    diff;

    always_comb
    begin
        partial = {rem_reg, rad_reg[SW-1:SW-2]};
        trial   = {2'b00, root_reg, 2'b01};
        take    = (partial >= trial);
        diff    = partial - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!run_reg && req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(RW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!run_reg && req.start)
        begin
            rad_reg  <= req.radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (run_reg)
        begin
            rad_reg  <= {rad_reg[SW-3:0], 2'b00};
            root_reg <= {root_reg[RW-2:0], take};
            rem_reg  <= take ? diff[RW+1:0] : partial[RW+1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

`default_nettype wire

// File: sv/thruster_mixer_with_thrust_inversion_top.sv
// Channel       | Ports                                                  | Flow
// --------------+--------------------------------------------------------+--------------------
// item in       | start, busy, operation, output_channel, input_channel, | taken when start
//               | value, last_control                                    | and !busy
// result out    | valid, channel, command, scaled_down, last             | one-cycle strobe
// configuration | cfg_we, cfg_index, cfg_data                            | written when cfg_we
//
// A coefficient load is written on acceptance and leaves busy low. A control item
// makes one read-multiply-write round through the accumulator RAM per output. The
// last control adds the final pass: per output an inversion step waiting on the
// shared divider and root unit, then per output an emission step waiting on the
// divider when results are scaled down. Reset clears control state, the valid bits
// standing for zeroed tables, and the linear and quadratic terms, and sets max revs
// to one; results cannot be stalled and leave one per emission step.
`default_nettype none

module thruster_mixer_with_thrust_inversion_top #(
    parameter int NUM_OUTPUTS = 8,
    parameter int NUM_INPUTS  = 6
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item transaction
    input  wire logic        start,
    output logic             busy,
    input  wire logic        operation,
    input  wire logic [2:0]  output_channel,
    input  wire logic [2:0]  input_channel,
    input  wire logic [15:0] value,
    input  wire logic        last_control,
    // result transaction
    output logic             valid,
    output logic [2:0]       channel,
    output logic [15:0]      command,
    output logic             scaled_down,
    output logic             last,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int DW         = tmix_pkg::DIV_W;
    localparam int SUMW       = tmix_pkg::SUM_W;
    localparam int COEF_DEPTH = NUM_OUTPUTS * NUM_INPUTS;
    localparam int CAW        = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int OW         = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
    localparam int LA_W       = CAW + 4;

    typedef enum logic [16:0] {
        S_IDLE    = 17'b00000000000000001,
        S_MAC_RD  = 17'b00000000000000010,
        S_MAC_MUL = 17'b00000000000000100,
        S_MAC_WR  = 17'b00000000000001000,
        S_F_RD    = 17'b00000000000010000,
        S_F_ABS   = 17'b00000000000100000,
        S_F_MUL   = 17'b00000000001000000,
        S_F_PATH  = 17'b00000000010000000,
        S_F_DIV_R = 17'b00000000100000000,
        S_F_SQRT  = 17'b00000001000000000,
        S_F_DIV_N = 17'b00000010000000000,
        S_F_NORM  = 17'b00000100000000000,
        S_F_DIV_X = 17'b00001000000000000,
        S_S_RD    = 17'b00010000000000000,
        S_S_ABS   = 17'b00100000000000000,
        S_S_DIV   = 17'b01000000000000000,
        S_S_OUT   = 17'b10000000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [31:0] lin_reg;
    logic [31:0] quad_reg;
    logic [31:0] mrev_reg;
    logic [31:0] mrev_eff;

    // sequencing
    logic [OW-1:0]  o_reg;
    logic [CAW-1:0] caddr_reg;
    logic           last_ctl_reg;
    logic [15:0]    val_reg;
    logic           o_last;

    // valid bits standing for the zero reset of the coefficient and sum tables
    logic [COEF_DEPTH-1:0]  coef_vld_reg;
    logic [NUM_OUTPUTS-1:0] sum_vld_reg;
    logic                   coef_vq_reg;
    logic                   sum_vq_reg;

    // datapath
    logic signed [31:0] prod_reg;
    logic [SUMW-1:0]    sumq_reg;
    logic [SUMW-1:0]    t_reg;
    logic               neg_reg;
    logic [63:0]        bb_reg;
    logic [60:0]        am_reg;
    logic [46:0]        nr_reg;
    logic [31:0]        largest_reg;
    logic               scaled_reg;
    logic [31:0]        q_reg;

    // result registers
    logic        valid_reg;
    logic [2:0]  channel_reg;
    logic [15:0] command_reg;
    logic        scaled_out_reg;
    logic        last_out_reg;

    // memories
    logic            coef_we;
    logic [CAW-1:0]  coef_waddr;
    logic [15:0]     coef_rdata;
    logic            sum_we;
    logic [SUMW-1:0] sum_wdata;
    logic [SUMW-1:0] sum_rdata;
    logic            norm_we;
    logic [31:0]     norm_wdata;
    logic [31:0]     norm_rdata;

    tmix_pkg::div_req_t  div_req;
    tmix_pkg::div_rsp_t  div_rsp;
    tmix_pkg::sqrt_req_t sqrt_req;
    tmix_pkg::sqrt_rsp_t sqrt_rsp;

    // combinational helpers
    logic            accept;
    logic            load_ok;
    logic            ctl_ok;
    logic [LA_W-1:0] load_addr;
    logic [SUMW:0]   mac_sum;
    logic [SUMW-1:0] mac_sat;
    logic [SUMW-1:0] sum_eff;
    logic [15:0]     coef_eff;
    logic [63:0]     d_val;
    logic [31:0]     bq;
    logic [31:0]     num;
    logic [30:0]     x_clamp;
    logic [31:0]     largest_upd;
    logic [31:0]     xa;

    tmix_ram #(.WIDTH(16), .DEPTH(COEF_DEPTH)) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (value),
        .raddr (caddr_reg),
        .rdata (coef_rdata)
    );

    tmix_ram #(.WIDTH(SUMW), .DEPTH(NUM_OUTPUTS)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (o_reg),
        .wdata (sum_wdata),
        .raddr (o_reg),
        .rdata (sum_rdata)
    );

    tmix_ram #(.WIDTH(32), .DEPTH(NUM_OUTPUTS)) u_norm_ram (
        .clk   (clk),
        .we    (norm_we),
        .waddr (o_reg),
        .wdata (norm_wdata),
        .raddr (o_reg),
        .rdata (norm_rdata)
    );

    tmix_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tmix_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    always_comb
    begin
        accept    = start && (state_reg == S_IDLE);
        load_ok   = ({2'b00, output_channel} < 5'(NUM_OUTPUTS))
                    && ({1'b0, input_channel} < 4'(NUM_INPUTS));
        ctl_ok    = ({1'b0, input_channel} < 4'(NUM_INPUTS));
        load_addr = LA_W'(output_channel) * LA_W'(NUM_INPUTS) + LA_W'(input_channel);
        coef_we   = accept && (operation == tmix_pkg::OP_LOAD) && load_ok;
        coef_waddr = load_addr[CAW-1:0];
        o_last    = (o_reg == OW'(NUM_OUTPUTS - 1));
        mrev_eff  = (mrev_reg == 32'd0) ? 32'd1 : mrev_reg;

        // accumulate with saturation to the signed 40-bit range
        mac_sum = {sumq_reg[SUMW-1], sumq_reg} + {{(SUMW-31){prod_reg[31]}}, prod_reg};
        if (mac_sum[SUMW] != mac_sum[SUMW-1])
        begin
            mac_sat = mac_sum[SUMW] ? {1'b1, {(SUMW-1){1'b0}}} : {1'b0, {(SUMW-1){1'b1}}};
        end
        else
        begin
            mac_sat = mac_sum[SUMW-1:0];
        end
        sum_we    = (state_reg == S_MAC_WR);
        sum_wdata = mac_sat;

        sum_eff  = sum_vq_reg ? sum_rdata : '0;
        coef_eff = coef_vq_reg ? coef_rdata : 16'd0;

        d_val = {4'b0000, bb_reg[63:4]} + {5'b00000, am_reg[60:2]};
        bq    = {2'b00, lin_reg[31:2]};
        num   = (sqrt_rsp.root > bq) ? (sqrt_rsp.root - bq) : 32'd0;

        x_clamp     = (div_rsp.quotient > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF
                                                         : div_rsp.quotient[30:0];
        largest_upd = ({1'b0, x_clamp} > largest_reg) ? {1'b0, x_clamp} : largest_reg;
        norm_we     = (state_reg == S_F_DIV_X) && div_rsp.done;
        norm_wdata  = neg_reg ? (32'd0 - {1'b0, x_clamp}) : {1'b0, x_clamp};

        xa = norm_rdata[31] ? (32'd0 - norm_rdata) : norm_rdata;
    end

    // requests to the shared divider and root unit
    always_comb
    begin
        div_req  = '0;
        sqrt_req = '0;
        unique case (state_reg)
            S_F_PATH:
            begin
                if (quad_reg == 32'd0 && lin_reg != 32'd0)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DW'(t_reg) << 5;
                    div_req.divisor  = lin_reg;
                end
                else if (lin_reg == 32'd0 && quad_reg != 32'd0)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DW'(t_reg) << 21;
                    div_req.divisor  = quad_reg;
                end
                else if (lin_reg != 32'd0)
                begin
                    sqrt_req.start    = 1'b1;
                    sqrt_req.radicand = d_val;
                end
            end
            S_F_DIV_R:
            begin
                sqrt_req.start    = div_rsp.done;
                sqrt_req.radicand = div_rsp.quotient;
            end
            S_F_SQRT:
            begin
                div_req.start    = sqrt_rsp.done && (lin_reg != 32'd0);
                div_req.dividend = DW'(num) << 17;
                div_req.divisor  = quad_reg;
            end
            S_F_NORM:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DW'(nr_reg) << 16;
                div_req.divisor  = mrev_eff;
            end
            S_S_ABS:
            begin
                div_req.start    = scaled_reg;
                div_req.dividend = DW'(xa) << 15;
                div_req.divisor  = largest_reg;
            end
            default:
            begin
                div_req  = '0;
                sqrt_req = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && operation == tmix_pkg::OP_CONTROL)
                begin
                    if (ctl_ok)
                    begin
                        state_next = S_MAC_RD;
                    end
                    else if (last_control)
                    begin
                        state_next = S_F_RD;
                    end
                end
            end
            S_MAC_RD:  state_next = S_MAC_MUL;
            S_MAC_MUL: state_next = S_MAC_WR;
            S_MAC_WR:
            begin
                if (!o_last)
                begin
                    state_next = S_MAC_RD;
                end
                else
                begin
                    state_next = last_ctl_reg ? S_F_RD : S_IDLE;
                end
            end
            S_F_RD:  state_next = S_F_ABS;
            S_F_ABS: state_next = S_F_MUL;
            S_F_MUL: state_next = S_F_PATH;
            S_F_PATH:
            begin
                if (quad_reg == 32'd0 && lin_reg == 32'd0)
                begin
                    state_next = S_F_NORM;
                end
                else if (quad_reg == 32'd0)
                begin
                    state_next = S_F_DIV_N;
                end
                else if (lin_reg == 32'd0)
                begin
                    state_next = S_F_DIV_R;
                end
                else
                begin
                    state_next = S_F_SQRT;
                end
            end
            S_F_DIV_R:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_F_SQRT;
                end
            end
            S_F_SQRT:
            begin
                if (sqrt_rsp.done)
                begin
                    state_next = (lin_reg == 32'd0) ? S_F_NORM : S_F_DIV_N;
                end
            end
            S_F_DIV_N:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_F_NORM;
                end
            end
            S_F_NORM: state_next = S_F_DIV_X;
            S_F_DIV_X:
            begin
                if (div_rsp.done)
                begin
                    state_next = o_last ? S_S_RD : S_F_RD;
                end
            end
            S_S_RD:  state_next = S_S_ABS;
            S_S_ABS: state_next = scaled_reg ? S_S_DIV : S_S_OUT;
            S_S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_S_OUT;
                end
            end
            S_S_OUT: state_next = o_last ? S_IDLE : S_S_RD;
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            lin_reg      <= 32'd0;
            quad_reg     <= 32'd0;
            mrev_reg     <= tmix_pkg::ONE_Q16;
            coef_vld_reg <= '0;
            sum_vld_reg  <= '0;
            largest_reg  <= tmix_pkg::ONE_Q16;
            scaled_reg   <= 1'b0;
            valid_reg    <= 1'b0;
            o_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_reg == S_S_OUT);

            if (cfg_we)
            begin
                unique case (cfg_index)
                    tmix_pkg::CFG_LINEAR:    lin_reg  <= cfg_data;
                    tmix_pkg::CFG_QUADRATIC: quad_reg <= cfg_data;
                    tmix_pkg::CFG_MAX_REVS:  mrev_reg <= cfg_data;
                    default:                 lin_reg  <= lin_reg;
                endcase
            end

            if (coef_we)
            begin
                coef_vld_reg[coef_waddr] <= 1'b1;
            end
            if (sum_we)
            begin
                sum_vld_reg[o_reg] <= 1'b1;
            end

            // start the final pass with largest at one
            if (state_next == S_F_RD && state_reg != S_F_DIV_X)
            begin
                largest_reg <= tmix_pkg::ONE_Q16;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    o_reg <= '0;
                end
                S_MAC_WR:
                begin
                    o_reg <= o_last ? '0 : o_reg + OW'(1);
                end
                S_F_DIV_X:
                begin
                    if (div_rsp.done)
                    begin
                        largest_reg <= largest_upd;
                        scaled_reg  <= (largest_upd > tmix_pkg::ONE_Q16);
                        o_reg       <= o_last ? '0 : o_reg + OW'(1);
                    end
                end
                S_S_OUT:
                begin
                    o_reg <= o_last ? '0 : o_reg + OW'(1);
                    if (o_last)
                    begin
                        // drop all accumulators back to zero
                        sum_vld_reg <= '0;
                    end
                end
                default:
                begin
                    o_reg <= o_reg;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        coef_vq_reg <= coef_vld_reg[caddr_reg];
        sum_vq_reg  <= sum_vld_reg[o_reg];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    val_reg      <= value;
                    last_ctl_reg <= last_control;
                    caddr_reg    <= CAW'(input_channel);
                end
            end
            S_MAC_MUL:
            begin
                prod_reg <= $signed(val_reg) * $signed(coef_eff);
                sumq_reg <= sum_eff;
            end
            S_MAC_WR:
            begin
                caddr_reg <= caddr_reg + CAW'(NUM_INPUTS);
            end
            S_F_ABS:
            begin
                neg_reg <= sum_eff[SUMW-1];
                t_reg   <= sum_eff[SUMW-1] ? (SUMW'(0) - sum_eff) : sum_eff;
            end
            S_F_MUL:
            begin
                bb_reg <= 64'(lin_reg) * 64'(lin_reg);
                am_reg <= 61'(quad_reg) * 61'(t_reg[SUMW-1:11]);
            end
            S_F_PATH:
            begin
                if (quad_reg == 32'd0 && lin_reg == 32'd0)
                begin
                    nr_reg <= '0;
                end
            end
            S_F_SQRT:
            begin
                if (sqrt_rsp.done && lin_reg == 32'd0)
                begin
                    nr_reg <= 47'(sqrt_rsp.root);
                end
            end
            S_F_DIV_N:
            begin
                if (div_rsp.done)
                begin
                    nr_reg <= (div_rsp.quotient > 64'(tmix_pkg::N_CAP)) ? tmix_pkg::N_CAP
                                                                         : div_rsp.quotient[46:0];
                end
            end
            S_S_ABS:
            begin
                neg_reg <= norm_rdata[31];
                q_reg   <= {1'b0, xa[31:1]};
            end
            S_S_DIV:
            begin
                if (div_rsp.done)
                begin
                    q_reg <= div_rsp.quotient[31:0];
                end
            end
            S_S_OUT:
            begin
                channel_reg    <= 3'(o_reg);
                scaled_out_reg <= scaled_reg;
                last_out_reg   <= o_last;
                if (neg_reg)
                begin
                    command_reg <= (q_reg > 32'd32768) ? 16'h8000 : (16'd0 - q_reg[15:0]);
                end
                else
                begin
                    command_reg <= (q_reg > 32'd32767) ? 16'h7FFF : q_reg[15:0];
                end
            end
            default:
            begin
                caddr_reg <= caddr_reg;
            end
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign valid       = valid_reg;
    assign channel     = channel_reg;
    assign command     = command_reg;
    assign scaled_down = scaled_out_reg;
    assign last        = last_out_reg;

endmodule

`default_nettype wire
